// ===== rtl/fsta_pkg.sv =====
// Package for the fixed-step tick accumulator.
// Holds widths, register indexes, reset values, the sequencer state type and
// the control bundle. No dependencies.
package fsta_pkg;

  // Accumulator width in bits; any value from 32 to 64 is supported.
  localparam int AccBits = 40;

  localparam int StepW  = 20;
  localparam int MaxW   = 8;
  localparam int FracW  = 16;
  localparam int MsW    = 16;
  localparam int CntW32 = 32;
  localparam int SimW   = 48;
  localparam int UsPerMs = 1000;
  localparam int AddW   = MsW + 10;
  localparam int UsedW  = StepW + MaxW;
  localparam int IterMax = (AccBits > FracW) ? AccBits : FracW;
  localparam int CntW   = $clog2(IterMax + 1);

  // APB register map: one word per register.
  localparam int PaddrW = 3;
  localparam int PdataW = 32;
  localparam logic RegStep = 1'b0;
  localparam logic RegMax  = 1'b1;

  localparam logic [StepW-1:0] StepReset = StepW'(16667);
  localparam logic [MaxW-1:0]  MaxReset  = MaxW'(5);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_DIV,
    ST_GRANT,
    ST_UPDATE,
    ST_FRAC,
    ST_DONE
  } fsta_state_e;

  // Per-state controls of the sequencer.
  typedef struct packed {
    logic accept;
    logic load_acc;
    logic div_run;
    logic grant;
    logic update;
    logic frac_run;
    logic deliver;
  } fsta_ctl_t;

endpackage

// ===== rtl/fsta_div_step.sv =====
// One restoring division step, shared by the tick quotient and the fraction.
// Depends on fsta_pkg for the step width.
module fsta_div_step (
  input  logic [fsta_pkg::StepW-1:0] part_rem_i,
  input  logic                       bit_i,
  input  logic [fsta_pkg::StepW-1:0] divisor_i,
  output logic [fsta_pkg::StepW-1:0] part_rem_o,
  output logic                       q_bit_o
);
  import fsta_pkg::*;

  logic [StepW:0]   trial;
  logic [StepW+1:0] diff;

  // Shift in one dividend bit and subtract the divisor where it fits.
  assign trial   = {part_rem_i, bit_i};
  assign diff    = {1'b0, trial} - {2'b00, divisor_i};
  assign q_bit_o = ~diff[StepW+1];
  assign part_rem_o = q_bit_o ? diff[StepW-1:0] : trial[StepW-1:0];

endmodule

// ===== rtl/fsta_core.sv =====
// Sequencer, state registers and result register of the tick accumulator.
// Depends on fsta_pkg and instantiates the shared step unit fsta_div_step.
module fsta_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       func_i,
  input  logic [fsta_pkg::MsW-1:0]   elapsed_ms_i,
  input  logic [fsta_pkg::StepW-1:0] step_i,
  input  logic [fsta_pkg::MaxW-1:0]  max_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       tick_granted_o,
  output logic [fsta_pkg::MaxW-1:0]  pending_ticks_o,
  output logic [fsta_pkg::FracW-1:0] interpolation_q16_o,
  output logic [fsta_pkg::CntW32-1:0] frames_seen_o,
  output logic [fsta_pkg::CntW32-1:0] ticks_total_o,
  output logic [fsta_pkg::SimW-1:0]  simulated_us_o
);
  import fsta_pkg::*;

  fsta_state_e state_q, state_d;
  fsta_ctl_t   ctl;

  logic [AccBits-1:0] acc_q;
  logic [AccBits-1:0] div_sh_q;
  logic [StepW-1:0]   rem_q;
  logic [CntW-1:0]    cnt_q;
  logic [AddW-1:0]    add_q;
  logic [MaxW-1:0]    pend_q;
  logic [MaxW-1:0]    ticks_q;
  logic [UsedW-1:0]   used_q;
  logic [FracW-1:0]   frac_q;
  logic [CntW32-1:0]  frames_q;
  logic [CntW32-1:0]  ticks_tot_q;
  logic [SimW-1:0]    sim_q;
  logic               granted_q;

  logic               out_valid_q;
  logic               out_granted_q;
  logic [MaxW-1:0]    out_pend_q;
  logic [FracW-1:0]   out_frac_q;
  logic [CntW32-1:0]  out_frames_q;
  logic [CntW32-1:0]  out_ticks_q;
  logic [SimW-1:0]    out_sim_q;

  logic [StepW-1:0]   step_eff;
  logic [AccBits:0]   sum;
  logic [MaxW-1:0]    ticks;
  logic               quot_small;
  logic               step_bit;
  logic [StepW-1:0]   step_rem;
  logic               step_q_bit;
  logic               out_free;

  // A step of zero counts as one microsecond.
  assign step_eff = (step_i == '0) ? StepW'(1) : step_i;

  // Sum of accumulator and new microseconds, with a carry bit for saturation.
  assign sum = {1'b0, acc_q} + (AccBits + 1)'(add_q);

  // Quotient clamped to the configured maximum.
  assign quot_small = (div_sh_q[AccBits-1:MaxW] == '0) && (div_sh_q[MaxW-1:0] < max_i);
  assign ticks      = quot_small ? div_sh_q[MaxW-1:0] : max_i;

  assign out_free = ~out_valid_q | ~out_stall_i;

  // Shared divider step: dividend bits while dividing the accumulator,
  // zeros while forming the fraction.
  assign step_bit = ctl.div_run ? div_sh_q[AccBits-1] : 1'b0;

  fsta_div_step u_div_step (
    .part_rem_i (rem_q),
    .bit_i      (step_bit),
    .divisor_i  (step_eff),
    .part_rem_o (step_rem),
    .q_bit_o    (step_q_bit)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = func_i ? ST_DONE : ST_ADD;
      end
      ST_ADD:    state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == '0) state_d = ST_GRANT;
      end
      ST_GRANT:  state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_FRAC;
      ST_FRAC: begin
        if (cnt_q == '0) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Controls for each state.
  always_comb begin
    ctl = '0;
    unique case (state_q)
      ST_IDLE:   ctl.accept   = in_valid_i;
      ST_ADD:    ctl.load_acc = 1'b1;
      ST_DIV:    ctl.div_run  = 1'b1;
      ST_GRANT:  ctl.grant    = 1'b1;
      ST_UPDATE: ctl.update   = 1'b1;
      ST_FRAC:   ctl.frac_run = 1'b1;
      ST_DONE:   ctl.deliver  = out_free;
      default:   ctl = '0;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Architectural state of the accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      pend_q      <= '0;
      frac_q      <= '0;
      frames_q    <= '0;
      ticks_tot_q <= '0;
      sim_q       <= '0;
      granted_q   <= 1'b0;
    end else begin
      if (ctl.accept) begin
        if (func_i) begin
          granted_q <= (pend_q != '0);
          if (pend_q != '0) pend_q <= pend_q - MaxW'(1);
        end else begin
          granted_q <= 1'b0;
          frames_q  <= frames_q + CntW32'(1);
        end
      end
      if (ctl.load_acc) begin
        acc_q <= sum[AccBits] ? '1 : sum[AccBits-1:0];
      end
      if (ctl.grant) begin
        pend_q <= ticks;
      end
      if (ctl.update) begin
        acc_q       <= acc_q - AccBits'(used_q);
        ticks_tot_q <= ticks_tot_q + CntW32'(ticks_q);
        sim_q       <= sim_q + SimW'(used_q);
      end
      if (ctl.frac_run) begin
        frac_q <= {frac_q[FracW-2:0], step_q_bit};
      end
    end
  end

  // Working registers of the divider sequence.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      if (ctl.load_acc) begin
        cnt_q <= CntW'(AccBits - 1);
      end else if (ctl.update) begin
        cnt_q <= CntW'(FracW - 1);
      end else if ((ctl.div_run || ctl.frac_run) && (cnt_q != '0)) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.accept) begin
      add_q <= AddW'(elapsed_ms_i) * AddW'(UsPerMs);
    end
    if (ctl.load_acc) begin
      div_sh_q <= sum[AccBits] ? '1 : sum[AccBits-1:0];
      rem_q    <= '0;
    end
    if (ctl.div_run) begin
      div_sh_q <= {div_sh_q[AccBits-2:0], step_q_bit};
      rem_q    <= step_rem;
    end
    if (ctl.frac_run) begin
      rem_q <= step_rem;
    end
    if (ctl.grant) begin
      ticks_q <= ticks;
      used_q  <= UsedW'(ticks) * UsedW'(step_eff);
    end
  end

  // Result register: holds one finished transaction for the consumer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.deliver) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.deliver) begin
      out_granted_q <= granted_q;
      out_pend_q    <= pend_q;
      out_frac_q    <= frac_q;
      out_frames_q  <= frames_q;
      out_ticks_q   <= ticks_tot_q;
      out_sim_q     <= sim_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign tick_granted_o      = out_granted_q;
  assign pending_ticks_o     = out_pend_q;
  assign interpolation_q16_o = out_frac_q;
  assign frames_seen_o       = out_frames_q;
  assign ticks_total_o       = out_ticks_q;
  assign simulated_us_o      = out_sim_q;

endmodule

// ===== rtl/fixed_step_tick_accumulator_unit.sv =====
// Top level of the fixed-step tick accumulator: APB register file and core.
// Depends on fsta_pkg and instantiates fsta_core.
//
// A frame transaction (func 0) adds elapsed_ms as microseconds to a
// saturating accumulator, grants up to the configured maximum of fixed
// ticks, removes them and reports the leftover as a Q0.16 fraction of a
// step; a poll transaction (func 1) hands out one pending tick. Every
// transaction gives exactly one result. A poll passes the done state to the
// result register; a frame first passes add, divide, grant, update and fraction
// states, one shared restoring divider step running 40 times for the tick
// quotient and 16 times for the fraction. One transaction is in work at a
// time; a finished result waits in the output register while the next is
// accepted. The user must write configuration only while idle; the block does not enforce it.
module fixed_step_tick_accumulator_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fsta_pkg::PaddrW-1:0]  paddr,
  input  logic [fsta_pkg::PdataW-1:0]  pwdata,
  output logic [fsta_pkg::PdataW-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic [fsta_pkg::MsW-1:0]     elapsed_ms_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         tick_granted_o,
  output logic [fsta_pkg::MaxW-1:0]    pending_ticks_o,
  output logic [fsta_pkg::FracW-1:0]   interpolation_q16_o,
  output logic [fsta_pkg::CntW32-1:0]  frames_seen_o,
  output logic [fsta_pkg::CntW32-1:0]  ticks_total_o,
  output logic [fsta_pkg::SimW-1:0]    simulated_us_o
);
  import fsta_pkg::*;

  logic [StepW-1:0] step_q;
  logic [MaxW-1:0]  max_q;
  logic             reg_sel;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepReset;
      max_q  <= MaxReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegStep: step_q <= pwdata[StepW-1:0];
        RegMax:  max_q  <= pwdata[MaxW-1:0];
        default: step_q <= step_q;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_sel)
      RegStep: prdata = PdataW'(step_q);
      RegMax:  prdata = PdataW'(max_q);
      default: prdata = '0;
    endcase
  end

  fsta_core u_core (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .func_i              (func_i),
    .elapsed_ms_i        (elapsed_ms_i),
    .step_i              (step_q),
    .max_i               (max_q),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .tick_granted_o      (tick_granted_o),
    .pending_ticks_o     (pending_ticks_o),
    .interpolation_q16_o (interpolation_q16_o),
    .frames_seen_o       (frames_seen_o),
    .ticks_total_o       (ticks_total_o),
    .simulated_us_o      (simulated_us_o)
  );

endmodule

// ===== verif/tb_fixed_step_tick_accumulator_unit.sv =====
// Self-checking testbench for fixed_step_tick_accumulator_unit.
// Depends on fsta_pkg; drives frame and poll transactions, programs the APB registers and
// checks every result against a cycle-free predictor held in a small scoreboard class.
`timescale 1ns / 100ps

module tb_fixed_step_tick_accumulator_unit;
  import fsta_pkg::*;

  // One result transaction, as seen on the output ports.
  typedef struct packed {
    logic              granted;
    logic [MaxW-1:0]   pending;
    logic [FracW-1:0]  frac;
    logic [CntW32-1:0] frames;
    logic [CntW32-1:0] ticks;
    logic [SimW-1:0]   sim_us;
  } tick_report_t;

  // Predicts the accumulator state and keeps the reports still owed by the block.
  class tick_ledger;
    logic [StepW-1:0]   step_reg;
    logic [MaxW-1:0]    max_reg;
    logic [AccBits-1:0] accum;
    logic [MaxW-1:0]    pend;
    logic [CntW32-1:0]  frames;
    logic [CntW32-1:0]  ticks;
    logic [SimW-1:0]    sim_us;
    logic [FracW-1:0]   frac;
    tick_report_t       owed[$];
    int unsigned        faults, checked, n_frames, n_polls, n_grants, n_sat;

    function new();
      step_reg = StepReset;
      max_reg  = MaxReset;
      accum    = '0;
      pend     = '0;
      frames   = '0;
      ticks    = '0;
      sim_us   = '0;
      frac     = '0;
      faults   = 0;
      checked  = 0;
      n_frames = 0;
      n_polls  = 0;
      n_grants = 0;
      n_sat    = 0;
    endfunction

    function void set_register(logic idx, logic [PdataW-1:0] val);
      if (idx == RegStep) begin
        step_reg = val[StepW-1:0];
      end else begin
        max_reg = val[MaxW-1:0];
      end
    endfunction

    // Works out the report caused by one accepted transaction.
    function void note_item(logic func, logic [MsW-1:0] ms);
      logic [63:0]  limit, add, sum, stp, quot, grant, used, rem;
      tick_report_t r;
      r.granted = 1'b0;
      if (func == 1'b0) begin
        n_frames++;
        limit = (64'd1 << AccBits) - 64'd1;
        add   = 64'(ms) * 64'd1000;
        sum   = 64'(accum) + add;
        // The accumulator saturates rather than wrapping.
        if (sum > limit) begin
          sum = limit;
          n_sat++;
        end
        // A step of zero behaves as a step of one microsecond.
        stp   = (step_reg == '0) ? 64'd1 : 64'(step_reg);
        quot  = sum / stp;
        grant = (quot < 64'(max_reg)) ? quot : 64'(max_reg);
        used  = grant * stp;
        sum   = sum - used;
        accum = AccBits'(sum);
        // The grant replaces whatever was still pending.
        pend   = MaxW'(grant);
        frames = frames + 1'b1;
        ticks  = ticks + CntW32'(grant);
        sim_us = sim_us + SimW'(used);
        rem    = sum % stp;
        frac   = FracW'((rem << 16) / stp);
      end else begin
        n_polls++;
        if (pend != '0) begin
          pend = pend - 1'b1;
          r.granted = 1'b1;
          n_grants++;
        end
      end
      r.pending = pend;
      r.frac    = frac;
      r.frames  = frames;
      r.ticks   = ticks;
      r.sim_us  = sim_us;
      owed.push_back(r);
    endfunction

    function void match(string field, logic [63:0] want, logic [63:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, actual %0d", field, want, seen);
        faults++;
      end
    endfunction

    // Compares one accepted result with the oldest report owed.
    function void check_result(tick_report_t got);
      tick_report_t want;
      if (owed.size() == 0) begin
        $error("result transaction arrived with no report owed");
        faults++;
        return;
      end
      want = owed.pop_front();
      checked++;
      match("tick_granted", 64'(want.granted), 64'(got.granted));
      match("pending_ticks", 64'(want.pending), 64'(got.pending));
      match("interpolation_q16", 64'(want.frac), 64'(got.frac));
      match("frames_seen", 64'(want.frames), 64'(got.frames));
      match("ticks_total", 64'(want.ticks), 64'(got.ticks));
      match("simulated_us", 64'(want.sim_us), 64'(got.sim_us));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PaddrW-1:0]   paddr = '0;
  logic [PdataW-1:0]   pwdata = '0;
  logic [PdataW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                func_i = 1'b0;
  logic [MsW-1:0]      elapsed_ms_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                tick_granted_o;
  logic [MaxW-1:0]     pending_ticks_o;
  logic [FracW-1:0]    interpolation_q16_o;
  logic [CntW32-1:0]   frames_seen_o;
  logic [CntW32-1:0]   ticks_total_o;
  logic [SimW-1:0]     simulated_us_o;

  tick_ledger  ledger = new();
  bit          idle_on = 1'b1;
  bit          held_once = 1'b0;
  int unsigned writes_done = 0;

  fixed_step_tick_accumulator_unit DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .func_i              (func_i),
    .elapsed_ms_i        (elapsed_ms_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .tick_granted_o      (tick_granted_o),
    .pending_ticks_o     (pending_ticks_o),
    .interpolation_q16_o (interpolation_q16_o),
    .frames_seen_o       (frames_seen_o),
    .ticks_total_o       (ticks_total_o),
    .simulated_us_o      (simulated_us_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Both handshakes are sampled at the rising edge.
  always @(posedge clk_i) begin : sample_ports
    tick_report_t seen;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      ledger.note_item(func_i, elapsed_ms_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.granted = tick_granted_o;
      seen.pending = pending_ticks_o;
      seen.frac    = interpolation_q16_o;
      seen.frames  = frames_seen_o;
      seen.ticks   = ticks_total_o;
      seen.sim_us  = simulated_us_o;
      ledger.check_result(seen);
    end
  end

  // Receiver: random stall bursts, one long hold-off so that the block backs up.
  initial begin
    int n;
    int hold_count;
    wait (rst_ni === 1'b1);
    forever begin
      if (!held_once && ledger.checked >= 400) begin
        held_once = 1'b1;
        hold_count = 0;
        while (hold_count < 600) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
          hold_count++;
        end
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 14);
        repeat (n) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end else begin
        n = $urandom_range(1, 20);
        repeat (n) begin
          @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Run limit, well beyond the slowest correct run.
  initial begin
    #60_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic pause_sender(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Offers one transaction and returns at the edge that accepts it.
  task automatic offer(logic func, logic [MsW-1:0] ms);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      pause_sender($urandom_range(1, 14));
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    func_i       <= func;
    elapsed_ms_i <= ms;
    do begin
      @(posedge clk_i);
    end while (in_stall_o !== 1'b0);
  endtask

  task automatic offer_frame(logic [MsW-1:0] ms);
    offer(1'b0, ms);
  endtask

  // The elapsed field of a poll is ignored, so it carries random bits.
  task automatic offer_poll();
    offer(1'b1, MsW'($urandom_range(0, 65535)));
  endtask

  // Waits until every owed report has come back and the block is idle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (ledger.owed.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(logic idx, logic [PdataW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (pready !== 1'b1);
    ledger.set_register(idx, val);
    writes_done++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Elapsed times mostly around a few steps, with some full-range and tiny ones.
  function automatic logic [MsW-1:0] pick_ms(logic [PdataW-1:0] step_v);
    int unsigned step_ms;
    int unsigned hi;
    int unsigned r;
    step_ms = step_v / 1000;
    if (step_ms == 0) step_ms = 1;
    hi = (3 * step_ms > 65535) ? 65535 : 3 * step_ms;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      return MsW'($urandom_range(0, hi));
    end else if (r < 8) begin
      return MsW'($urandom_range(0, 65535));
    end
    return MsW'($urandom_range(0, 20));
  endfunction

  // One setting: mostly a frame followed by polls for its grant, with some noise.
  task automatic run_phase(logic [PdataW-1:0] step_v, logic [PdataW-1:0] max_v, int items);
    int sent;
    int npoll;
    drain();
    write_reg(RegStep, step_v);
    write_reg(RegMax, max_v);
    sent = 0;
    while (sent < items) begin
      idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) < 7) begin
        offer_frame(pick_ms(step_v));
        sent++;
        npoll = int'(ledger.pend);
        if (npoll > 24 && $urandom_range(0, 3) != 0) npoll = $urandom_range(1, 24);
        npoll += $urandom_range(0, 1);
        repeat (npoll) begin
          offer_poll();
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          offer(1'($urandom_range(0, 1)), MsW'($urandom_range(0, 65535)));
          sent++;
        end
      end
    end
  endtask

  // Main sequence.
  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: empty poll, zero frame, ordinary grant, clamped grant.
    offer_poll();
    offer_frame(16'd0);
    offer_frame(16'd50);
    repeat (3) offer_poll();
    offer_frame(16'hFFFF);
    // A new step leaves the reported fraction alone until the next frame.
    drain();
    write_reg(RegStep, 32'd10007);
    repeat (6) offer_poll();
    offer_frame(16'd1);

    // Zero step and zero maximum.
    drain();
    write_reg(RegStep, 32'd0);
    write_reg(RegMax, 32'd0);
    offer_frame(16'd3);
    offer_poll();
    offer_frame(16'd0);

    // Widest step and largest maximum.
    drain();
    write_reg(RegStep, 32'hF_FFFF);
    write_reg(RegMax, 32'd255);
    offer_frame(16'hFFFF);
    repeat (2) offer_poll();

    // Smallest step, one tick per frame, alternating bit patterns.
    drain();
    write_reg(RegStep, 32'd1);
    write_reg(RegMax, 32'd1);
    offer_frame(16'h5555);
    offer_frame(16'hAAAA);
    offer_poll();

    // Random part over a spread of settings.
    run_phase(32'd16667, 32'd5, 120);
    run_phase(32'd5000, 32'd8, 120);
    run_phase(32'd1000000, 32'd1, 120);
    run_phase(32'hF_FFFF, 32'd255, 120);
    run_phase(32'd0, 32'd3, 120);
    run_phase(32'd1, 32'd255, 120);
    run_phase(32'd33333, 32'd0, 120);
    run_phase(32'($urandom_range(1000, 100000)), 32'($urandom_range(1, 12)), 120);
    run_phase(32'($urandom_range(1, 1048575)), 32'($urandom_range(1, 255)), 120);

    // Last part, without idling: build up a large backlog, then grant from it in one frame.
    drain();
    idle_on = 1'b0;
    write_reg(RegStep, 32'd999983);
    write_reg(RegMax, 32'd0);
    repeat (20) offer_frame(16'hFFFF);
    drain();
    write_reg(RegStep, 32'd1000000);
    write_reg(RegMax, 32'd255);
    offer_frame(16'hFFFF);
    repeat (3) offer_poll();

    drain();
    repeat (70) @(posedge clk_i);

    $display("Checked %0d results: %0d frames and %0d polls (%0d granted) over %0d writes.",
             ledger.checked, ledger.n_frames, ledger.n_polls, ledger.n_grants, writes_done);
    $display("The accumulator saturated on %0d frames.", ledger.n_sat);
    if (ledger.faults == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
